// ===== hw/rtl/idq_pkg.sv =====
// Shared types and constants for the indexed double-ended queue.
// Holds the opcode and status encodings and the fixed payload widths.
// No dependencies.
package idq_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 5;
   localparam int OCC_W   = 5;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_CLEAR      = 3'd4,
      OP_WRITE      = 3'd5,
      OP_READ       = 3'd6
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_BADPOS = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

endpackage

// ===== hw/rtl/indexed_double_ended_queue_top.sv =====
// Indexed double-ended queue: top level with ring pointers and response stage.
// Depends on idq_pkg and idq_mem.
//
// Usage:
//   Request channel (req_*): opcode, value, position. One transaction per
//   request; every request yields exactly one response transaction.
//   Response channel (rsp_*): read_value, status, occupancy after the request.
//   Latency: the response is valid the cycle after the request is accepted.
//   Throughput: one request per cycle. Pointer and count registers update at
//   the accepting edge, and the entry store is read or written in that same
//   cycle; its registered read lines up with the response register.
//   Stall: while a response waits for rsp_ready, req_ready stays high only if
//   the response is taken in that cycle; the held read data stays put.
//   Reset: empties the queue (front pointer and count to zero) and drops any
//   pending response. Entry contents are not cleared; a read only ever names
//   an entry that was written.
module indexed_double_ended_queue_top
   import idq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [2:0]                 req_opcode,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic [POS_W-1:0]           req_position,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [VALUE_W-1:0]  rsp_read_value,
   output logic [1:0]                 rsp_status,
   output logic [OCC_W-1:0]           rsp_occupancy
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = CW + POS_W;

   logic [PW-1:0]    front_ff, front_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             rsp_valid_ff;
   status_type       status_ff, status_in;
   logic [OCC_W-1:0] occ_ff;
   logic             rd_ok_ff, rd_ok_in;

   logic             accept;
   logic             full, empty, pos_ok;
   logic [XW-1:0]    pos_ext, cnt_ext, occ_ext;
   logic [POS_W-1:0] pos_m1;
   logic [PW+POS_W:0] pos_m1_ext;
   logic [PW:0]      offset, ring_sum;
   logic [PW-1:0]    ring_addr;
   logic             wr_en, rd_en;
   logic signed [VALUE_W-1:0] rd_data;

   assign accept    = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;

   // Queue status flags and position check
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign pos_ext = {{CW{1'b0}}, req_position};
   assign cnt_ext = {{POS_W{1'b0}}, count_ff};
   assign pos_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext);

   // Pick the ring offset: count for push back, position minus one otherwise
   assign pos_m1     = req_position - POS_W'(1);
   assign pos_m1_ext = {{(PW+1){1'b0}}, pos_m1};
   always_comb begin
      if (opcode_type'(req_opcode) == OP_PUSH_BACK) begin
         offset = (PW+1)'(count_ff);
      end else begin
         offset = pos_m1_ext[PW:0];
      end
   end

   // Wrap front plus offset around the ring
   assign ring_sum = {1'b0, front_ff} + offset;
   always_comb begin
      if (ring_sum >= (PW+1)'(DEPTH)) begin
         ring_addr = PW'(ring_sum - (PW+1)'(DEPTH));
      end else begin
         ring_addr = ring_sum[PW-1:0];
      end
   end

   // Decode the request into pointer updates and store accesses
   logic [PW-1:0] wr_addr;
   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      status_in = ST_OK;
      rd_ok_in  = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      wr_addr   = ring_addr;
      case (opcode_type'(req_opcode))
         OP_PUSH_FRONT: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               front_in = (front_ff == '0) ? PW'(DEPTH - 1) : front_ff - PW'(1);
               wr_addr  = front_in;
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         OP_PUSH_BACK: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               front_in = (front_ff == PW'(DEPTH - 1)) ? '0 : front_ff + PW'(1);
               count_in = count_ff - CW'(1);
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status_in = ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         OP_CLEAR: begin
            front_in = '0;
            count_in = '0;
         end
         OP_WRITE: begin
            if (pos_ok) begin
               wr_en = 1'b1;
            end else begin
               status_in = ST_BADPOS;
            end
         end
         OP_READ: begin
            if (pos_ok) begin
               rd_en    = 1'b1;
               rd_ok_in = 1'b1;
            end else begin
               status_in = ST_BADPOS;
            end
         end
         default: begin
         end
      endcase
   end

   idq_mem #(
      .DEPTH (DEPTH),
      .AW    (PW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (accept && wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_value),
      .rd_en   (accept && rd_en),
      .rd_addr (ring_addr),
      .rd_data (rd_data)
   );

   // Advance pointers and the response valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the response payload for the current transaction
   assign occ_ext = {{POS_W{1'b0}}, count_in};
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         occ_ff    <= occ_ext[OCC_W-1:0];
         rd_ok_ff  <= rd_ok_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_occupancy  = occ_ff;
   assign rsp_read_value = rd_ok_ff ? rd_data : '0;

endmodule

// ===== hw/rtl/idq_mem.sv =====
// Entry store of the queue: one write port, one read port, registered read.
// Depends on idq_pkg for the word width.
module idq_mem
   import idq_pkg::*;
#(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  logic signed [VALUE_W-1:0]  wr_data,
   input  logic                       rd_en,
   input  logic [AW-1:0]              rd_addr,
   output logic signed [VALUE_W-1:0]  rd_data
);

   logic signed [VALUE_W-1:0] entry_mem [DEPTH];
   logic signed [VALUE_W-1:0] rd_data_ff;

   // Write one word per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
   end

   // Load read data only on a read, so it holds while the response stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/idq_response_checker.sv =====
`timescale 1ns / 100ps
// Response checker for the indexed double-ended queue testbench: watches both
// channels, keeps its own ring model of the queue and compares each response.
// Depends on idq_pkg for payload widths, opcode and status encodings.
module idq_response_checker
   import idq_pkg::*;
#(
   parameter int RING_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [2:0]                req_opcode,
   input  logic signed [VALUE_W-1:0] req_value,
   input  logic [POS_W-1:0]          req_position,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic signed [VALUE_W-1:0] rsp_read_value,
   input  logic [1:0]                rsp_status,
   input  logic [OCC_W-1:0]          rsp_occupancy,
   output int                        mismatch_count,
   output int                        replies_owed
);

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [1:0]                status;
      logic [OCC_W-1:0]          occupancy;
   } queue_reply_type;

   // Model state: ring of words, front index and fill level
   logic signed [VALUE_W-1:0] ring_words [RING_DEPTH];
   int unsigned               head_idx;
   int unsigned               fill_count;
   queue_reply_type           owed_replies [$];

   // Apply one request to the ring model and return the response it implies
   function automatic queue_reply_type apply_request(input logic [2:0] op,
                                                     input logic signed [VALUE_W-1:0] word,
                                                     input logic [POS_W-1:0] pos);
      queue_reply_type reply;
      int unsigned     slot;
      reply.read_value = '0;
      reply.status     = ST_OK;
      case (op)
         OP_PUSH_FRONT: begin
            if (fill_count >= RING_DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               head_idx = (head_idx + RING_DEPTH - 1) % RING_DEPTH;
               ring_words[head_idx] = word;
               fill_count++;
            end
         end
         OP_PUSH_BACK: begin
            if (fill_count >= RING_DEPTH) begin
               reply.status = ST_FULL;
            end else begin
               ring_words[(head_idx + fill_count) % RING_DEPTH] = word;
               fill_count++;
            end
         end
         OP_POP_FRONT: begin
            if (fill_count == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               head_idx = (head_idx + 1) % RING_DEPTH;
               fill_count--;
            end
         end
         OP_POP_BACK: begin
            if (fill_count == 0) begin
               reply.status = ST_EMPTY;
            end else begin
               fill_count--;
            end
         end
         OP_CLEAR: begin
            fill_count = 0;
            head_idx   = 0;
         end
         OP_WRITE, OP_READ: begin
            if (pos == 0 || pos > fill_count) begin
               reply.status = ST_BADPOS;
            end else begin
               slot = (head_idx + pos - 1) % RING_DEPTH;
               if (op == OP_WRITE) begin
                  ring_words[slot] = word;
               end else begin
                  reply.read_value = ring_words[slot];
               end
            end
         end
         // unused opcode: leave the queue alone
         default: ;
      endcase
      reply.occupancy = OCC_W'(fill_count);
      return reply;
   endfunction

   // Count a failure, describe only the first ten
   task automatic log_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("%0t idq check: %s", $time, what);
      end
   endtask

   always @(posedge clock) begin
      queue_reply_type want;
      if (reset) begin
         head_idx       = 0;
         fill_count     = 0;
         mismatch_count = 0;
         owed_replies.delete();
         replies_owed   = 0;
      end else begin
         // Check the response first: it answers an earlier transaction
         if (rsp_valid && rsp_ready) begin
            if (owed_replies.size() == 0) begin
               log_mismatch($sformatf("unexpected response value %0d status %0d occ %0d",
                                      rsp_read_value, rsp_status, rsp_occupancy));
            end else begin
               want = owed_replies.pop_front();
               if (want.read_value !== rsp_read_value || want.status !== rsp_status ||
                   want.occupancy !== rsp_occupancy) begin
                  log_mismatch($sformatf({"expected value %0d status %0d occ %0d, ",
                                          "got value %0d status %0d occ %0d"},
                                         want.read_value, want.status, want.occupancy,
                                         rsp_read_value, rsp_status, rsp_occupancy));
               end
            end
         end
         // Predict the response of a newly accepted request
         if (req_valid && req_ready) begin
            owed_replies.push_back(apply_request(req_opcode, req_value, req_position));
         end
         replies_owed = owed_replies.size();
      end
   end

endmodule

// ===== tb/tb_indexed_double_ended_queue_top.sv =====
`timescale 1ns / 100ps
// Testbench top for the indexed double-ended queue: clock, reset, request
// stimulus, response back-pressure and the verdict.
// Depends on idq_pkg, indexed_double_ended_queue_top and idq_response_checker.
module tb_indexed_double_ended_queue_top
   import idq_pkg::*;
;

   localparam int QUEUE_DEPTH  = 16;
   localparam int RANDOM_ITEMS = 1350;
   localparam int CALM_TAIL    = 150;
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam logic signed [VALUE_W-1:0] WORD_MAX = 32'sh7fffffff;
   localparam logic signed [VALUE_W-1:0] WORD_MIN = 32'sh80000000;

   logic                      clock        = 1'b0;
   logic                      reset        = 1'b1;
   logic                      req_valid    = 1'b0;
   logic                      req_ready;
   logic [2:0]                req_opcode   = '0;
   logic signed [VALUE_W-1:0] req_value    = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic                      rsp_valid;
   logic                      rsp_ready    = 1'b1;
   logic signed [VALUE_W-1:0] rsp_read_value;
   logic [1:0]                rsp_status;
   logic [OCC_W-1:0]          rsp_occupancy;

   logic stalls_on  = 1'b0;
   int   stall_left = 0;
   int   fill_guess = 0;
   int   mismatch_count;
   int   replies_owed;

   always #6 clock = ~clock;

   indexed_double_ended_queue_top #(
      .DEPTH(QUEUE_DEPTH)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_value(rsp_read_value),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy)
   );

   idq_response_checker #(
      .RING_DEPTH(QUEUE_DEPTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_value     (req_value),
      .req_position  (req_position),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_read_value(rsp_read_value),
      .rsp_status    (rsp_status),
      .rsp_occupancy (rsp_occupancy),
      .mismatch_count(mismatch_count),
      .replies_owed  (replies_owed)
   );

   // Stall the response side in random bursts while stalls are enabled
   always @(posedge clock) begin
      if (!stalls_on) begin
         stall_left = 0;
      end
      if (stalls_on && stall_left == 0 && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 18);
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Present one request and hold it until the transaction completes
   task automatic send_request(input logic [2:0] op,
                               input logic signed [VALUE_W-1:0] word,
                               input logic [POS_W-1:0] pos);
      logic took;
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_value    <= word;
      req_position <= pos;
      do begin
         @(negedge clock);
         took = req_ready;
         @(posedge clock);
      end while (!took);
      // track the fill level to steer positions and push/pop balance
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: if (fill_guess < QUEUE_DEPTH) fill_guess++;
         OP_POP_FRONT, OP_POP_BACK:   if (fill_guess > 0) fill_guess--;
         OP_CLEAR:                    fill_guess = 0;
         default: ;
      endcase
   endtask

   initial begin
      int                        n;
      int                        tilt;
      int                        roll;
      int                        push_pct;
      logic                      calm;
      logic [2:0]                op;
      logic signed [VALUE_W-1:0] word;
      logic [POS_W-1:0]          pos;
      tilt = 2;
      repeat (9) @(posedge clock);
      reset     <= 1'b0;
      stalls_on <= 1'b1;

      // Corners of the empty queue, including the unused opcode
      send_request(OP_POP_FRONT, '0, '0);
      send_request(OP_POP_BACK, '1, 5'd31);
      send_request(OP_READ, '0, 5'd1);
      send_request(OP_WRITE, WORD_MAX, 5'd0);
      send_request(OP_UNUSED, '1, 5'd1);

      // Fill both ends with extreme words, overflow both, read edges, pop, clear
      send_request(OP_PUSH_BACK, WORD_MAX, '0);
      send_request(OP_PUSH_FRONT, WORD_MIN, '0);
      for (n = 0; n < QUEUE_DEPTH - 2; n++) begin
         send_request((n % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom, '0);
      end
      send_request(OP_PUSH_FRONT, 32'sd1, '0);
      send_request(OP_PUSH_BACK, -32'sd1, '0);
      send_request(OP_READ, '0, 5'd16);
      send_request(OP_READ, '0, 5'd17);
      send_request(OP_POP_BACK, '0, '0);
      send_request(OP_CLEAR, '0, '0);

      // Random traffic that drifts between empty and full
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 60 == 0) tilt = $urandom_range(0, 2);
         // calm stretches and the tail run without gaps on either side
         calm = (n >= RANDOM_ITEMS - CALM_TAIL) || ((n / 90) % 4 == 3);
         stalls_on <= !calm;
         if (!calm && $urandom_range(0, 4) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
         end

         push_pct = (tilt == 0) ? 75 : (tilt == 1) ? 25 : 50;
         roll = $urandom_range(0, 99);
         if (roll < 1) op = OP_CLEAR;
         else if (roll < 2) op = OP_UNUSED;
         else if (roll < 22) op = OP_READ;
         else if (roll < 38) op = OP_WRITE;
         else if ($urandom_range(0, 99) < push_pct)
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
         else
            op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;

         // Mostly valid positions for indexed access, some out of range
         pos = POS_W'($urandom);
         if (op == OP_READ || op == OP_WRITE) begin
            roll = $urandom_range(0, 9);
            if (roll < 8 && fill_guess > 0) pos = POS_W'($urandom_range(1, fill_guess));
            else if (roll == 8) pos = '0;
            else pos = POS_W'($urandom_range(fill_guess + 1, 31));
         end

         word = $urandom;
         if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
               0:       word = '0;
               1:       word = WORD_MAX;
               2:       word = WORD_MIN;
               default: word = '1;
            endcase
         end
         send_request(op, word, pos);
      end
      req_valid <= 1'b0;

      // Drain outstanding responses, then let the pipeline settle
      do @(negedge clock); while (replies_owed != 0);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[indexed_double_ended_queue_top] OK");
      end else begin
         $display("[indexed_double_ended_queue_top] ERROR");
      end
      $finish;
   end

   // Watchdog for a hung handshake
   initial begin
      #5_000_000;
      $display("[indexed_double_ended_queue_top] ERROR");
      $finish;
   end

endmodule
